FILE: rtl/core/imm_pkg.sv
// shared types and constants of the integer matrix multiplier
package imm_pkg;

    // width of the row and column index fields on the ports
    localparam int IDX_BITS = 3;
    // width of a dimension register and of the config data port
    localparam int DIM_BITS = 4;
    // width of the config register index
    localparam int CFG_IDX_BITS = 2;

    // request codes carried by req_type
    localparam logic [1:0] REQ_WRITE_A = 2'd0;
    localparam logic [1:0] REQ_WRITE_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLS_B    = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                wr_a;       // store elem_value into A
        logic                wr_b;       // store elem_value into B
        logic                rd_en;      // issue one multiply-accumulate step
        logic                first_k;    // first step of a result element
        logic                last_k;     // last step of a result element
        logic                zero;       // empty inner dimension, product forced to zero
        logic                last_elem;  // step belongs to the final result element
        logic [IDX_BITS-1:0] row;        // result row
        logic [IDX_BITS-1:0] col;        // result column
        logic [IDX_BITS-1:0] kk;         // position along the inner dimension
    } imm_cmd_t;

    // pipeline status from the datapath to the controller
    typedef struct packed {
        logic rd_valid;   // read data stage holds a step
        logic mul_valid;  // product stage holds a step
    } imm_status_t;

endpackage

FILE: rtl/core/integer_matrix_multiply_top.sv
// top level of the integer matrix multiplier: config registers, controller and datapath
//
// usage
//   config port: cfg_wr_en, cfg_addr, cfg_wdata write rows_a (0), inner_dim (1) or
//   cols_b (2), one register per write; write only while busy is low. Sizes above MAX_DIM saturate.
//   input: a transaction is taken at a clock edge with start high and busy low.
//   req_type selects write A, write B or compute. A write stores elem_value at row_index,
//   col_index; busy stays low, so writes stream one per cycle outside compute runs.
//   A compute transaction with nonzero rows_a and cols_b raises busy and walks C in
//   row-major order, one multiply-accumulate step per cycle through the store read ports,
//   the multiplier register and the accumulator.
//   output: each result is held for one cycle with out_strobe high; last_out marks the
//   final element. The receiver cannot stall, so nothing waits on it.
//   reset: rst_n clears the controller and the strobes and sets every size to 3;
//   operand store contents are undefined until written.
module integer_matrix_multiply_top #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [imm_pkg::CFG_IDX_BITS-1:0]      cfg_addr,
    input  logic [imm_pkg::DIM_BITS-1:0]          cfg_wdata,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            req_type,
    input  logic [imm_pkg::IDX_BITS-1:0]          row_index,
    input  logic [imm_pkg::IDX_BITS-1:0]          col_index,
    input  logic signed [31:0]                    elem_value,
    output logic                                  out_strobe,
    output logic [imm_pkg::IDX_BITS-1:0]          out_row,
    output logic [imm_pkg::IDX_BITS-1:0]          out_col,
    output logic signed [31:0]                    product_value,
    output logic                                  last_out
);

    logic [imm_pkg::DIM_BITS-1:0] rows_a_reg;
    logic [imm_pkg::DIM_BITS-1:0] inner_dim_reg;
    logic [imm_pkg::DIM_BITS-1:0] cols_b_reg;

    imm_pkg::imm_cmd_t    cmd;
    imm_pkg::imm_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= imm_pkg::DIM_BITS'(3);
            inner_dim_reg <= imm_pkg::DIM_BITS'(3);
            cols_b_reg    <= imm_pkg::DIM_BITS'(3);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                imm_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                imm_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                imm_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    imm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .row_index (row_index),
        .col_index (col_index),
        .rows_a    (rows_a_reg),
        .inner_dim (inner_dim_reg),
        .cols_b    (cols_b_reg),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    imm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .row_index     (row_index),
        .col_index     (col_index),
        .elem_value    (elem_value),
        .status        (status),
        .out_strobe    (out_strobe),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last_out      (last_out)
    );

`ifndef SYNTHESIS
    // results only come out of a compute run
    assert property (@(posedge clk) disable iff (!rst_n) out_strobe |-> busy)
        else $error("result strobe while idle");

    // the final element ends the run
    assert property (@(posedge clk) disable iff (!rst_n) (out_strobe && last_out) |=> !busy)
        else $error("still busy after the final result");

    // result coordinates stay inside the configured size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> ((imm_pkg::DIM_BITS'(out_row) < rows_a_reg)
                        && (imm_pkg::DIM_BITS'(out_col) < cols_b_reg)))
        else $error("result coordinates out of range");

    // a run starts only from an accepted compute transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req_type == imm_pkg::REQ_COMPUTE)))
        else $error("busy raised without a compute transaction");
`endif

endmodule

FILE: rtl/core/imm_ram.sv
// generic single-write, single-read ram with registered read data
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/imm_datapath.sv
// operand stores, multiplier and accumulator of the matrix multiplier
module imm_datapath #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  imm_pkg::imm_cmd_t                 cmd,
    input  logic [imm_pkg::IDX_BITS-1:0]      row_index,
    input  logic [imm_pkg::IDX_BITS-1:0]      col_index,
    input  logic signed [31:0]                elem_value,
    output imm_pkg::imm_status_t              status,
    output logic                              out_strobe,
    output logic [imm_pkg::IDX_BITS-1:0]      out_row,
    output logic [imm_pkg::IDX_BITS-1:0]      out_col,
    output logic signed [31:0]                product_value,
    output logic                              last_out
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     a_addr;
    logic [ADDR_W-1:0]     b_addr;
    logic [DATA_WIDTH-1:0] a_data;
    logic [DATA_WIDTH-1:0] b_data;
    logic [DATA_WIDTH-1:0] mul_low;
    logic [DATA_WIDTH-1:0] acc_sum;

    // read stage flags
    logic                         rd_valid_reg;
    logic                         rd_first_reg;
    logic                         rd_last_k_reg;
    logic                         rd_zero_reg;
    logic                         rd_last_elem_reg;
    logic [imm_pkg::IDX_BITS-1:0] rd_row_reg;
    logic [imm_pkg::IDX_BITS-1:0] rd_col_reg;

    // product stage
    logic                         mul_valid_reg;
    logic                         mul_first_reg;
    logic                         mul_last_k_reg;
    logic                         mul_last_elem_reg;
    logic [imm_pkg::IDX_BITS-1:0] mul_row_reg;
    logic [imm_pkg::IDX_BITS-1:0] mul_col_reg;
    logic [DATA_WIDTH-1:0]        prod_reg;

    // accumulator and result register
    logic [DATA_WIDTH-1:0]        acc_reg;
    logic                         res_strobe_reg;
    logic                         res_last_reg;
    logic [imm_pkg::IDX_BITS-1:0] res_row_reg;
    logic [imm_pkg::IDX_BITS-1:0] res_col_reg;
    logic signed [DATA_WIDTH-1:0] res_value_reg;

    // store addresses, row-major with MAX_DIM entries per row
    assign wr_addr = ADDR_W'(row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index);
    assign a_addr  = ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.kk);
    assign b_addr  = ADDR_W'(cmd.kk) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col);

    imm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (cmd.wr_a),
        .wr_addr (wr_addr),
        .wr_data (elem_value[DATA_WIDTH-1:0]),
        .rd_en   (cmd.rd_en),
        .rd_addr (a_addr),
        .rd_data (a_data)
    );

    imm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (cmd.wr_b),
        .wr_addr (wr_addr),
        .wr_data (elem_value[DATA_WIDTH-1:0]),
        .rd_en   (cmd.rd_en),
        .rd_addr (b_addr),
        .rd_data (b_data)
    );

    // low half of the product is all that survives the wrap
    assign mul_low = a_data * b_data;

    // running sum restarts on the first step of each element
    assign acc_sum = mul_first_reg ? prod_reg : acc_reg + prod_reg;

    // stage valids and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            mul_valid_reg  <= 1'b0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.rd_en;
            mul_valid_reg  <= rd_valid_reg;
            res_strobe_reg <= mul_valid_reg && mul_last_k_reg;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_first_reg     <= cmd.first_k;
            rd_last_k_reg    <= cmd.last_k;
            rd_zero_reg      <= cmd.zero;
            rd_last_elem_reg <= cmd.last_elem;
            rd_row_reg       <= cmd.row;
            rd_col_reg       <= cmd.col;
        end
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prod_reg          <= rd_zero_reg ? '0 : mul_low;
            mul_first_reg     <= rd_first_reg;
            mul_last_k_reg    <= rd_last_k_reg;
            mul_last_elem_reg <= rd_last_elem_reg;
            mul_row_reg       <= rd_row_reg;
            mul_col_reg       <= rd_col_reg;
        end
    end

    // accumulate and capture finished elements
    always_ff @(posedge clk)
    begin
        if (mul_valid_reg)
        begin
            acc_reg <= acc_sum;
            if (mul_last_k_reg)
            begin
                res_value_reg <= acc_sum;
                res_row_reg   <= mul_row_reg;
                res_col_reg   <= mul_col_reg;
                res_last_reg  <= mul_last_elem_reg;
            end
        end
    end

    assign status.rd_valid  = rd_valid_reg;
    assign status.mul_valid = mul_valid_reg;

    assign out_strobe    = res_strobe_reg;
    assign out_row       = res_row_reg;
    assign out_col       = res_col_reg;
    assign product_value = 32'(res_value_reg);
    assign last_out      = res_last_reg;

endmodule

FILE: rtl/core/imm_ctrl.sv
// controller: accepts transactions and sequences the multiply-accumulate steps
module imm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        req_type,
    input  logic [imm_pkg::IDX_BITS-1:0]      row_index,
    input  logic [imm_pkg::IDX_BITS-1:0]      col_index,
    input  logic [imm_pkg::DIM_BITS-1:0]      rows_a,
    input  logic [imm_pkg::DIM_BITS-1:0]      inner_dim,
    input  logic [imm_pkg::DIM_BITS-1:0]      cols_b,
    input  imm_pkg::imm_status_t              status,
    output imm_pkg::imm_cmd_t                 cmd,
    output logic                              busy
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;

    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
    logic [DIM_W-1:0] k_lim;
    logic             accept;
    logic             in_range;
    logic             i_last;
    logic             j_last;
    logic             k_last;

    // dimensions saturate at MAX_DIM
    assign nr = (rows_a > imm_pkg::DIM_BITS'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(rows_a);
    assign nk = (inner_dim > imm_pkg::DIM_BITS'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                          : DIM_W'(inner_dim);
    assign nc = (cols_b > imm_pkg::DIM_BITS'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cols_b);

    // an empty inner dimension still takes one step, with the product forced to zero
    assign k_lim = (nk == '0) ? DIM_W'(1) : nk;

    assign i_last = (DIM_W'(i_reg) + DIM_W'(1)) == nr;
    assign j_last = (DIM_W'(j_reg) + DIM_W'(1)) == nc;
    assign k_last = (DIM_W'(k_reg) + DIM_W'(1)) == k_lim;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);

    // store writes go straight through in the accepting cycle
    assign cmd.wr_a = accept && (req_type == imm_pkg::REQ_WRITE_A) && in_range;
    assign cmd.wr_b = accept && (req_type == imm_pkg::REQ_WRITE_B) && in_range;

    // step commands while running
    assign cmd.rd_en     = (state_reg == ST_RUN);
    assign cmd.first_k   = (k_reg == '0);
    assign cmd.last_k    = k_last;
    assign cmd.zero      = (nk == '0);
    assign cmd.last_elem = k_last && j_last && i_last;
    assign cmd.row       = imm_pkg::IDX_BITS'(i_reg);
    assign cmd.col       = imm_pkg::IDX_BITS'(j_reg);
    assign cmd.kk        = imm_pkg::IDX_BITS'(k_reg);

    // next state and loop counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == imm_pkg::REQ_COMPUTE) && (nr != '0) && (nc != '0))
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (k_last)
                begin
                    k_next = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!status.rd_valid && !status.mul_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

FILE: test/tb_integer_matrix_multiply_top.sv
// self-checking testbench for the integer matrix multiplier top level
`timescale 1ns / 100ps

module tb_integer_matrix_multiply_top;

    import imm_pkg::*;

    // codes that the package leaves unnamed
    localparam logic [1:0]              REQ_RESERVED = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED   = 2'd3;

    localparam int DIM_LIMIT    = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // one expected element of C
    typedef struct {
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic [31:0]         value;
        logic                is_last;
    } c_elem_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_addr;
    logic [DIM_BITS-1:0]     cfg_wdata;
    logic                    start;
    logic                    busy;
    logic [1:0]              req_type;
    logic [IDX_BITS-1:0]     row_index;
    logic [IDX_BITS-1:0]     col_index;
    logic signed [31:0]      elem_value;
    logic                    out_strobe;
    logic [IDX_BITS-1:0]     out_row;
    logic [IDX_BITS-1:0]     out_col;
    logic signed [31:0]      product_value;
    logic                    last_out;

    // predictor state: sizes, operand stores and which entries hold data
    logic [DIM_BITS-1:0] dim_rows;
    logic [DIM_BITS-1:0] dim_inner;
    logic [DIM_BITS-1:0] dim_cols;
    logic [31:0]         a_mem [DIM_LIMIT*DIM_LIMIT];
    logic [31:0]         b_mem [DIM_LIMIT*DIM_LIMIT];
    logic                a_written [DIM_LIMIT*DIM_LIMIT];
    logic                b_written [DIM_LIMIT*DIM_LIMIT];

    c_elem_t c_expected [$];
    int      err_cnt;
    int      cycle_cnt;
    bit      idle_en;

    integer_matrix_multiply_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .row_index     (row_index),
        .col_index     (col_index),
        .elem_value    (elem_value),
        .out_strobe    (out_strobe),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last_out      (last_out)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic int clamp_dim(input logic [DIM_BITS-1:0] v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : int'(v);
    endfunction

    // operand values weighted toward the extremes
    function automatic logic [31:0] rand_elem();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = 32'h7fff_ffff;
            1: v = 32'h8000_0000;
            2: v = 32'hffff_ffff;
            3: v = 32'h0000_0000;
            4: v = 32'($urandom_range(0, 200)) - 32'd100;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_dim();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(1, 4);
        else if (sel < 85)
            return $urandom_range(5, 8);
        else if (sel < 93)
            return 0;
        else
            return $urandom_range(9, 15);
    endfunction

    // row-major walk of C with 32-bit wrapped dot products
    function automatic void predict_products();
        int          nr;
        int          nk;
        int          nc;
        logic [31:0] acc;
        c_elem_t     e;
        nr = clamp_dim(dim_rows);
        nk = clamp_dim(dim_inner);
        nc = clamp_dim(dim_cols);
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                acc = '0;
                for (int k = 0; k < nk; k++)
                    acc = acc + a_mem[i*DIM_LIMIT+k] * b_mem[k*DIM_LIMIT+j];
                e.row     = IDX_BITS'(i);
                e.col     = IDX_BITS'(j);
                e.value   = acc;
                e.is_last = (i == nr - 1) && (j == nc - 1);
                c_expected.push_back(e);
            end
        end
    endfunction

    // present one transaction, wait for it to be taken, then update the predictor
    task automatic send_item(input logic [1:0] rq, input logic [IDX_BITS-1:0] r,
                             input logic [IDX_BITS-1:0] c, input logic [31:0] v);
        int addr;
        while (idle_en && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= rq;
        row_index  <= r;
        col_index  <= c;
        elem_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        addr = int'(r) * DIM_LIMIT + int'(c);
        case (rq)
            REQ_WRITE_A:
            begin
                a_mem[addr]     = v;
                a_written[addr] = 1'b1;
            end
            REQ_WRITE_B:
            begin
                b_mem[addr]     = v;
                b_written[addr] = 1'b1;
            end
            REQ_COMPUTE: predict_products();
            default: ;
        endcase
    endtask

    // hold the sender until every result is in and the block has settled
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (c_expected.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [DIM_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_ROWS_A:    dim_rows  = val;
            CFG_INNER_DIM: dim_inner = val;
            CFG_COLS_B:    dim_cols  = val;
            default: ;
        endcase
    endtask

    task automatic set_dims(input int r, input int k, input int c);
        wait_idle();
        write_reg(CFG_ROWS_A, DIM_BITS'(r));
        write_reg(CFG_INNER_DIM, DIM_BITS'(k));
        write_reg(CFG_COLS_B, DIM_BITS'(c));
        cfg_wr_en <= 1'b0;
    endtask

    // write every operand entry that the next compute reads and that holds no data yet, then send the compute
    task automatic run_compute();
        int nr;
        int nk;
        int nc;
        nr = clamp_dim(dim_rows);
        nk = clamp_dim(dim_inner);
        nc = clamp_dim(dim_cols);
        if (nr > 0 && nc > 0)
        begin
            for (int i = 0; i < nr; i++)
                for (int k = 0; k < nk; k++)
                    if (!a_written[i*DIM_LIMIT+k])
                        send_item(REQ_WRITE_A, IDX_BITS'(i), IDX_BITS'(k), rand_elem());
            for (int k = 0; k < nk; k++)
                for (int j = 0; j < nc; j++)
                    if (!b_written[k*DIM_LIMIT+j])
                        send_item(REQ_WRITE_B, IDX_BITS'(k), IDX_BITS'(j), rand_elem());
        end
        send_item(REQ_COMPUTE, IDX_BITS'($urandom), IDX_BITS'($urandom), $urandom);
    endtask

    // compare each result transaction with the oldest expected element
    always @(posedge clk)
    begin : check_results
        c_elem_t want;
        if (rst_n && out_strobe)
        begin
            if (c_expected.size() == 0)
            begin
                $error("unexpected result row %0d col %0d value %0d", out_row, out_col,
                       product_value);
                err_cnt++;
            end
            else
            begin
                want = c_expected.pop_front();
                if (out_row !== want.row)
                begin
                    $error("out_row expected %0d actual %0d", want.row, out_row);
                    err_cnt++;
                end
                if (out_col !== want.col)
                begin
                    $error("out_col expected %0d actual %0d", want.col, out_col);
                    err_cnt++;
                end
                if (product_value !== want.value)
                begin
                    $error("product_value expected %0d actual %0d", $signed(want.value),
                           product_value);
                    err_cnt++;
                end
                if (last_out !== want.is_last)
                begin
                    $error("last_out expected %0d actual %0d", want.is_last, last_out);
                    err_cnt++;
                end
            end
        end
    end

    // default 3x3x3 sizes out of reset, operands at the value extremes
    task automatic test_reset_defaults();
        logic [31:0] ext [6];
        ext = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1, 32'h8000_0001};
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                send_item(REQ_WRITE_A, IDX_BITS'(i), IDX_BITS'(k), ext[(i*3+k)%6]);
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                send_item(REQ_WRITE_B, IDX_BITS'(k), IDX_BITS'(j), ext[(k*3+j+2)%6]);
        run_compute();
    endtask

    // writes at the highest indexes, outside the configured size, are kept
    task automatic test_corner_writes();
        send_item(REQ_WRITE_A, 3'd7, 3'd7, 32'h8000_0000);
        send_item(REQ_WRITE_B, 3'd7, 3'd0, 32'h7fff_ffff);
        send_item(REQ_WRITE_A, 3'd0, 3'd7, 32'hffff_ffff);
        send_item(REQ_WRITE_B, 3'd0, 3'd7, 32'h7fff_ffff);
        run_compute();
    endtask

    // request code 3 leaves the stores alone and emits nothing
    task automatic test_reserved_request();
        send_item(REQ_RESERVED, 3'd0, 3'd0, 32'h1234_5678);
        send_item(REQ_RESERVED, 3'd7, 3'd7, 32'hffff_ffff);
        send_item(REQ_RESERVED, IDX_BITS'($urandom), IDX_BITS'($urandom), $urandom);
        run_compute();
    endtask

    // smallest, largest, zero and saturating sizes, plus a write to the unused index
    task automatic test_size_extremes();
        set_dims(1, 1, 1);
        run_compute();
        set_dims(8, 8, 8);
        run_compute();
        set_dims(0, 5, 5);
        run_compute();
        set_dims(5, 5, 0);
        run_compute();
        set_dims(4, 0, 3);
        run_compute();
        set_dims(15, 12, 9);
        run_compute();
        set_dims(0, 0, 0);
        run_compute();
        set_dims(2, 3, 4);
        wait_idle();
        write_reg(CFG_UNUSED, 4'hf);
        cfg_wr_en <= 1'b0;
        run_compute();
    endtask

    // phases of random sizes, each a stream of loads with computes and reserved requests mixed in
    task automatic test_random_traffic();
        int sel;
        for (int ph = 0; ph < 10; ph++)
        begin
            set_dims(pick_dim(), pick_dim(), pick_dim());
            idle_en = !(ph == 4 || ph == 5);
            for (int n = 0; n < 32; n++)
            begin
                if (ph == 2 && n == 20)
                    wait_idle();
                sel = $urandom_range(99);
                if (sel < 44)
                    send_item(REQ_WRITE_A, IDX_BITS'($urandom), IDX_BITS'($urandom),
                              rand_elem());
                else if (sel < 84)
                    send_item(REQ_WRITE_B, IDX_BITS'($urandom), IDX_BITS'($urandom),
                              rand_elem());
                else if (sel < 96)
                    run_compute();
                else
                    send_item(REQ_RESERVED, IDX_BITS'($urandom), IDX_BITS'($urandom),
                              $urandom);
            end
        end
        idle_en = 1'b1;
    endtask

    // main sequence
    initial
    begin
        rst_n      <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_addr   <= '0;
        cfg_wdata  <= '0;
        start      <= 1'b0;
        req_type   <= REQ_WRITE_A;
        row_index  <= '0;
        col_index  <= '0;
        elem_value <= '0;
        err_cnt    = 0;
        idle_en    = 1'b1;
        dim_rows   = 4'd3;
        dim_inner  = 4'd3;
        dim_cols   = 4'd3;
        for (int i = 0; i < DIM_LIMIT*DIM_LIMIT; i++)
        begin
            a_mem[i]     = '0;
            b_mem[i]     = '0;
            a_written[i] = 1'b0;
            b_written[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_corner_writes();
        test_reserved_request();
        test_size_extremes();
        test_random_traffic();
        wait_idle();

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
